@@ sv/bis_pkg.sv @@
// Shared types, sizes and codes for the indexed block search.
package bis_pkg;

  // Storage geometry.
  localparam int MAX_BLOCKS = 8;
  localparam int BLOCK_SIZE = 8;
  localparam int DEPTH      = MAX_BLOCKS * BLOCK_SIZE;

  // Field and index widths.
  localparam int BLK_W  = 3;
  localparam int OFF_W  = 3;
  localparam int ADDR_W = BLK_W + OFF_W;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int REG_W  = 4;
  localparam int CNT_W  = 4;
  localparam int CIDX_W = 1;

  // Most negative element value, the reset value of every block maximum.
  localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

  // Register reset values.
  localparam logic [REG_W-1:0] BLOCKS_RST = 4'd3;
  localparam logic [REG_W-1:0] LENGTH_RST = 4'd6;

  // Register indexes.
  localparam logic [CIDX_W-1:0] REG_BLOCKS_IN_USE = 1'b0;
  localparam logic [CIDX_W-1:0] REG_BLOCK_LENGTH  = 1'b1;

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [VAL_W-1:0] elem_t;

  // Limited configuration handed to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] nblk;
    logic [CNT_W-1:0] len;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAX  = 4'b0010,
    ST_ELEM = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage

@@ sv/bis_if.sv @@
// Handshake channels for load/query transactions and search results.
interface bis_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [bis_pkg::BLK_W-1:0]     block_number;
  logic [bis_pkg::OFF_W-1:0]     offset_in_block;
  logic signed [bis_pkg::VAL_W-1:0] value;

  modport source (output valid, operation, block_number, offset_in_block, value,
                  input ready);
  modport sink   (input valid, operation, block_number, offset_in_block, value,
                  output ready);
endinterface

interface bis_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [bis_pkg::POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

@@ sv/block_index_search.sv @@
// Indexed block search top level: configuration registers, sequencer and element store.
// A load takes no result. A query is accepted, then scans the maxima of the first blocks_in_use
// blocks, then scans up to block_length elements of the chosen block through the registered
// read port, then hands off its result, waiting while the prior result is still held.
// Synchronous active-low reset clears the block maxima to the most negative value and
// restores blocks_in_use to 3 and block_length to 6; the element store is not cleared.
module block_index_search (
  input  logic                         clk,
  input  logic                         rst_n,
  bis_in_if.sink                       in_ch,
  bis_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [bis_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bis_pkg::REG_W-1:0]    cfg_wdata
);

  logic [bis_pkg::REG_W-1:0]   blocks_in_use_r;
  logic [bis_pkg::REG_W-1:0]   block_length_r;
  bis_pkg::cfg_t               cfg;
  logic                        ram_we;
  logic [bis_pkg::ADDR_W-1:0]  ram_waddr;
  logic [bis_pkg::VAL_W-1:0]   ram_wdata;
  logic [bis_pkg::ADDR_W-1:0]  ram_raddr;
  logic [bis_pkg::VAL_W-1:0]   ram_rdata;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_in_use_r <= bis_pkg::BLOCKS_RST;
      block_length_r  <= bis_pkg::LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bis_pkg::REG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_wdata;
        bis_pkg::REG_BLOCK_LENGTH:  block_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Limit the registers to the storage geometry.
  always_comb begin
    cfg.nblk = (blocks_in_use_r > bis_pkg::CNT_W'(bis_pkg::MAX_BLOCKS))
               ? bis_pkg::CNT_W'(bis_pkg::MAX_BLOCKS) : blocks_in_use_r;
    cfg.len  = (block_length_r > bis_pkg::CNT_W'(bis_pkg::BLOCK_SIZE))
               ? bis_pkg::CNT_W'(bis_pkg::BLOCK_SIZE) : block_length_r;
  end

  bis_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bis_ram #(
    .WIDTH (bis_pkg::VAL_W),
    .DEPTH (bis_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ sv/bis_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bis_seq.sv @@
// Search sequencer: block maximum table, shared compare unit and result register.
module bis_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bis_pkg::cfg_t                cfg,
  bis_in_if.sink                       in_ch,
  bis_out_if.source                    out_ch,
  output logic                         ram_we,
  output logic [bis_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [bis_pkg::VAL_W-1:0]    ram_wdata,
  output logic [bis_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [bis_pkg::VAL_W-1:0]    ram_rdata
);

  bis_pkg::state_t                 state_r, state_nxt;
  bis_pkg::elem_t                  max_r [bis_pkg::MAX_BLOCKS];
  bis_pkg::elem_t                  key_r, key_nxt;
  bis_pkg::elem_t                  best_r, best_nxt;
  bis_pkg::elem_t                  cur_max;
  logic [bis_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [bis_pkg::BLK_W-1:0]       chosen_r, chosen_nxt;
  logic                            have_r, have_nxt;
  logic                            rd_v_r, rd_v_nxt;
  logic [bis_pkg::OFF_W-1:0]       rd_off_r, rd_off_nxt;
  logic                            res_found_r, res_found_nxt;
  logic [bis_pkg::POS_W-1:0]       res_pos_r, res_pos_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [bis_pkg::POS_W-1:0]       out_pos_r, out_pos_nxt;
  logic                            in_fire;
  logic                            do_load;
  logic                            issue;
  logic [bis_pkg::POS_W:0]         pos_full;

  assign in_ch.ready     = (state_r == bis_pkg::ST_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign do_load         = in_fire && (in_ch.operation == bis_pkg::OP_LOAD);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.position = out_pos_r;

  // A load writes the element store directly from the transaction.
  assign ram_we    = do_load;
  assign ram_waddr = {in_ch.block_number, in_ch.offset_in_block};
  assign ram_wdata = in_ch.value;
  assign ram_raddr = {chosen_r, cnt_r[bis_pkg::OFF_W-1:0]};

  assign cur_max = max_r[cnt_r[bis_pkg::BLK_W-1:0]];
  assign issue   = (cnt_r < cfg.len);
  assign pos_full = (bis_pkg::POS_W+1)'(chosen_r) * (bis_pkg::POS_W+1)'(cfg.len)
                    + (bis_pkg::POS_W+1)'(rd_off_r);

  // Next-state logic of the search sequencer.
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    best_nxt      = best_r;
    cnt_nxt       = cnt_r;
    chosen_nxt    = chosen_r;
    have_nxt      = have_r;
    rd_v_nxt      = 1'b0;
    rd_off_nxt    = rd_off_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    unique case (state_r)
      bis_pkg::ST_IDLE: begin
        if (in_fire && (in_ch.operation == bis_pkg::OP_QUERY)) begin
          key_nxt       = in_ch.value;
          cnt_nxt       = '0;
          have_nxt      = 1'b0;
          chosen_nxt    = '0;
          res_found_nxt = 1'b0;
          res_pos_nxt   = '0;
          state_nxt     = (cfg.nblk == '0) ? bis_pkg::ST_DONE : bis_pkg::ST_MAX;
        end
      end
      bis_pkg::ST_MAX: begin
        // One block maximum per cycle through the shared comparator.
        if ((cur_max >= key_r) && (!have_r || (cur_max < best_r))) begin
          best_nxt   = cur_max;
          chosen_nxt = cnt_r[bis_pkg::BLK_W-1:0];
          have_nxt   = 1'b1;
        end
        if (cnt_r == cfg.nblk - 1'b1) begin
          cnt_nxt   = '0;
          state_nxt = (have_nxt && (cfg.len != '0)) ? bis_pkg::ST_ELEM
                                                    : bis_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bis_pkg::ST_ELEM: begin
        // Reads are issued one per cycle; each is compared in the next cycle.
        rd_v_nxt   = issue;
        rd_off_nxt = cnt_r[bis_pkg::OFF_W-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_v_r) begin
          if (ram_rdata == key_r) begin
            res_found_nxt = 1'b1;
            res_pos_nxt   = pos_full[bis_pkg::POS_W-1:0];
            state_nxt     = bis_pkg::ST_DONE;
          end else if ({1'b0, rd_off_r} == cfg.len - 1'b1) begin
            state_nxt = bis_pkg::ST_DONE;
          end
        end
      end
      bis_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_pos_r;
          state_nxt     = bis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bis_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bis_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= rd_v_nxt;
    end
  end

  // Block maxima: reset to the most negative value, only ever raised by a load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bis_pkg::MAX_BLOCKS; i++) begin
        max_r[i] <= bis_pkg::MOST_NEG;
      end
    end else if (do_load && (in_ch.value > max_r[in_ch.block_number])) begin
      max_r[in_ch.block_number] <= in_ch.value;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    best_r      <= best_nxt;
    cnt_r       <= cnt_nxt;
    chosen_r    <= chosen_nxt;
    have_r      <= have_nxt;
    rd_off_r    <= rd_off_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

endmodule
